>>> hdl/pphl_pkg.sv
// ----------------------------------------------------------------------------
// pphl_pkg
// Shared widths, command, status and register codes, and the request and
// result records of the select/ack handshake link.
// ----------------------------------------------------------------------------
package pphl_pkg;

  localparam int unsigned CmdW    = 2;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned LimitW  = 17;
  localparam int unsigned StatusW = 3;
  localparam int unsigned TallyW  = 16;
  localparam int unsigned CfgIdxW = 4;

  localparam logic [CmdW-1:0] CMD_TICK  = 2'd0;
  localparam logic [CmdW-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CmdW-1:0] CMD_SEND  = 2'd2;
  localparam logic [CmdW-1:0] CMD_RECV  = 2'd3;

  localparam logic [StatusW-1:0] ST_OK          = 3'd0;
  localparam logic [StatusW-1:0] ST_SEND_RISE   = 3'd1;
  localparam logic [StatusW-1:0] ST_SEND_FALL   = 3'd2;
  localparam logic [StatusW-1:0] ST_RECV_EDGE12 = 3'd3;
  localparam logic [StatusW-1:0] ST_RECV_EDGE3  = 3'd4;
  localparam logic [StatusW-1:0] ST_RECV_FINAL  = 3'd5;

  localparam logic [CfgIdxW-1:0] REG_SEND_LIMIT = 4'd0;
  localparam logic [CfgIdxW-1:0] REG_RECV_LIMIT = 4'd1;

  localparam logic [LimitW-1:0] SEND_LIMIT_RST = 17'd100000;
  localparam logic [LimitW-1:0] RECV_LIMIT_RST = 17'd10000;
  localparam logic [ByteW-1:0]  PARITY_FAIL_BYTE = 8'hff;

  typedef struct packed {
    logic [ByteW-1:0]   data_drive;
    logic               select_ctrl;
    logic               op_done;
    logic [StatusW-1:0] status_code;
    logic [ByteW-1:0]   rx_byte;
    logic               engine_busy;
    logic               ack_pending;
    logic [TallyW-1:0]  parity_errors;
  } result_t;

  typedef struct packed {
    logic [CmdW-1:0]  cmd;
    logic [ByteW-1:0] tx_byte;
    logic             ack_line;
    logic             select_line;
    logic             paperout_line;
    logic             busy_line;
  } request_t;

endpackage

>>> hdl/pphl_if.sv
// ----------------------------------------------------------------------------
// pphl interfaces
// Request, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface pphl_in_if import pphl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CmdW-1:0]  cmd;
  logic [ByteW-1:0] tx_byte;
  logic             ack_line;
  logic             select_line;
  logic             paperout_line;
  logic             busy_line;

  modport source (output valid, cmd, tx_byte, ack_line, select_line, paperout_line,
                  busy_line, input ready);
  modport sink (input valid, cmd, tx_byte, ack_line, select_line, paperout_line,
                busy_line, output ready);
endinterface

interface pphl_out_if import pphl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ByteW-1:0]   data_drive;
  logic               select_ctrl;
  logic               op_done;
  logic [StatusW-1:0] status_code;
  logic [ByteW-1:0]   rx_byte;
  logic               engine_busy;
  logic               ack_pending;
  logic [TallyW-1:0]  parity_errors;

  modport source (output valid, data_drive, select_ctrl, op_done, status_code, rx_byte,
                  engine_busy, ack_pending, parity_errors, input ready);
  modport sink (input valid, data_drive, select_ctrl, op_done, status_code, rx_byte,
                engine_busy, ack_pending, parity_errors, output ready);
endinterface

interface pphl_cfg_if import pphl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [LimitW-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/parallel_port_handshake_link.sv
// ----------------------------------------------------------------------------
// parallel_port_handshake_link
// Host side of a select/ack handshake link for a parallel port.
// ----------------------------------------------------------------------------
// Each request on in_chan is a tick carrying the sampled ack, select,
// paperout and busy lines, or a clear, send or receive command. Commands are
// ignored while a transfer is running. Every request yields exactly one
// result on out_chan with the data and select drive levels, completion and
// status, the received byte and the parity error count.
// The result appears in the output register in the cycle after the request is
// taken. One request is taken per cycle while the output is not stalled; the
// handshake state machine moves at most one phase per tick, and its next state is formed in the same cycle.
// When the receiver stalls, the output register holds its result and
// in_chan.ready follows out_chan.ready, so no result is lost.
// cfg_chan writes the send and receive wait limits; it is always ready.
// After reset the limits are 100000 and 10000 ticks, the engine is idle,
// the select bit is set and the data drive is zero.
// ----------------------------------------------------------------------------
module parallel_port_handshake_link import pphl_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  pphl_in_if.sink   in_chan,
  pphl_out_if.source out_chan,
  pphl_cfg_if.sink  cfg_chan
);

  logic [LimitW-1:0] send_limit_q, recv_limit_q;
  logic              out_valid_q;
  result_t           res_q, res_d;
  request_t          req;
  logic              in_acc;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      send_limit_q <= SEND_LIMIT_RST;
      recv_limit_q <= RECV_LIMIT_RST;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        REG_SEND_LIMIT: send_limit_q <= cfg_chan.data;
        REG_RECV_LIMIT: recv_limit_q <= cfg_chan.data;
        default: ;
      endcase
    end
  end

  assign in_chan.ready = !out_valid_q || out_chan.ready;
  assign in_acc        = in_chan.valid && in_chan.ready;

  always_comb begin
    req.cmd           = in_chan.cmd;
    req.tx_byte       = in_chan.tx_byte;
    req.ack_line      = in_chan.ack_line;
    req.select_line   = in_chan.select_line;
    req.paperout_line = in_chan.paperout_line;
    req.busy_line     = in_chan.busy_line;
  end

  pphl_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (in_acc),
    .req_i        (req),
    .send_limit_i (send_limit_q),
    .recv_limit_i (recv_limit_q),
    .res_o        (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_chan.ready) begin
      out_valid_q <= in_chan.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q <= res_d;
    end
  end

  assign out_chan.valid         = out_valid_q;
  assign out_chan.data_drive    = res_q.data_drive;
  assign out_chan.select_ctrl   = res_q.select_ctrl;
  assign out_chan.op_done       = res_q.op_done;
  assign out_chan.status_code   = res_q.status_code;
  assign out_chan.rx_byte       = res_q.rx_byte;
  assign out_chan.engine_busy   = res_q.engine_busy;
  assign out_chan.ack_pending   = res_q.ack_pending;
  assign out_chan.parity_errors = res_q.parity_errors;

endmodule

>>> hdl/pphl_engine.sv
// ----------------------------------------------------------------------------
// pphl_engine
// Handshake state machine: advances at most one phase per accepted request and forms
// the result for that request.
// ----------------------------------------------------------------------------
module pphl_engine import pphl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  request_t          req_i,
  input  logic [LimitW-1:0] send_limit_i,
  input  logic [LimitW-1:0] recv_limit_i,
  output result_t           res_o
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_S_HI = 3'd1;
  localparam logic [2:0] PH_S_LO = 3'd2;
  localparam logic [2:0] PH_R_E1 = 3'd3;
  localparam logic [2:0] PH_R_E2 = 3'd4;
  localparam logic [2:0] PH_R_E3 = 3'd5;
  localparam logic [2:0] PH_R_E4 = 3'd6;

  logic [2:0]        phase_q, phase_d;
  logic [LimitW-1:0] wait_q, wait_d;
  logic [ByteW-1:0]  asm_q, asm_d;
  logic              pfail_q, pfail_d;
  logic [ByteW-1:0]  data_q, data_d;
  logic              sel_q, sel_d;
  logic [TallyW-1:0] tally_q, tally_d;

  logic               nbusy, is_send, want_high, hit;
  logic [LimitW-1:0]  limit;
  logic [ByteW-1:0]   byte_e3;
  logic               done;
  logic [StatusW-1:0] status;
  logic [ByteW-1:0]   rx;

  assign nbusy     = ~req_i.busy_line;
  assign is_send   = (phase_q == PH_S_HI) || (phase_q == PH_S_LO);
  assign want_high = (phase_q == PH_S_HI) || (phase_q == PH_R_E1) || (phase_q == PH_R_E3);
  assign limit     = is_send ? send_limit_i : recv_limit_i;
  assign hit       = (req_i.ack_line == want_high);
  assign byte_e3   = {req_i.paperout_line, req_i.select_line, asm_q[5:0]};

  always_comb begin
    phase_d = phase_q;
    wait_d  = wait_q;
    asm_d   = asm_q;
    pfail_d = pfail_q;
    data_d  = data_q;
    sel_d   = sel_q;
    tally_d = tally_q;
    done    = 1'b0;
    status  = ST_OK;
    rx      = '0;
    if (req_i.cmd != CMD_TICK) begin
      if (phase_q == PH_IDLE) begin
        case (req_i.cmd)
          CMD_CLEAR: begin
            sel_d   = 1'b1;
            data_d  = '0;
            tally_d = '0;
          end
          CMD_SEND: begin
            data_d  = req_i.tx_byte;
            sel_d   = 1'b0;
            wait_d  = '0;
            phase_d = PH_S_HI;
          end
          default: begin
            wait_d  = '0;
            phase_d = PH_R_E1;
          end
        endcase
      end
    end else if (phase_q != PH_IDLE) begin
      if (hit) begin
        wait_d = '0;
        case (phase_q)
          PH_S_HI: begin
            sel_d   = 1'b1;
            phase_d = PH_S_LO;
          end
          PH_S_LO: begin
            done    = 1'b1;
            phase_d = PH_IDLE;
          end
          PH_R_E1: begin
            asm_d   = {5'd0, nbusy, req_i.paperout_line, req_i.select_line};
            sel_d   = 1'b0;
            phase_d = PH_R_E2;
          end
          PH_R_E2: begin
            asm_d   = {2'd0, nbusy, req_i.paperout_line, req_i.select_line, asm_q[2:0]};
            sel_d   = 1'b1;
            phase_d = PH_R_E3;
          end
          PH_R_E3: begin
            asm_d = byte_e3;
            if (nbusy != ^byte_e3) begin
              data_d  = PARITY_FAIL_BYTE;
              pfail_d = 1'b1;
              if (tally_q != '1) begin
                tally_d = tally_q + 1'b1;
              end
            end else begin
              data_d  = '0;
              pfail_d = 1'b0;
            end
            sel_d   = 1'b0;
            phase_d = PH_R_E4;
          end
          default: begin
            sel_d = 1'b1;
            if (pfail_q) begin
              phase_d = PH_R_E1;
            end else begin
              done    = 1'b1;
              rx      = asm_q;
              phase_d = PH_IDLE;
            end
          end
        endcase
      end else if (wait_q >= limit) begin
        case (phase_q)
          PH_S_HI: status = ST_SEND_RISE;
          PH_S_LO: status = ST_SEND_FALL;
          PH_R_E1, PH_R_E2: status = ST_RECV_EDGE12;
          PH_R_E3: status = ST_RECV_EDGE3;
          default: status = ST_RECV_FINAL;
        endcase
        sel_d   = 1'b1;
        done    = 1'b1;
        phase_d = PH_IDLE;
        wait_d  = '0;
      end else begin
        wait_d = wait_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      wait_q  <= '0;
      asm_q   <= '0;
      pfail_q <= 1'b0;
      data_q  <= '0;
      sel_q   <= 1'b1;
      tally_q <= '0;
    end else if (en_i) begin
      phase_q <= phase_d;
      wait_q  <= wait_d;
      asm_q   <= asm_d;
      pfail_q <= pfail_d;
      data_q  <= data_d;
      sel_q   <= sel_d;
      tally_q <= tally_d;
    end
  end

  always_comb begin
    res_o.data_drive    = data_d;
    res_o.select_ctrl   = sel_d;
    res_o.op_done       = done;
    res_o.status_code   = status;
    res_o.rx_byte       = rx;
    res_o.engine_busy   = (phase_d != PH_IDLE);
    res_o.ack_pending   = req_i.ack_line;
    res_o.parity_errors = tally_d;
  end

endmodule

>>> hdl/pphl_checker.sv
// ----------------------------------------------------------------------------
// pphl_checker
// Port-level checks of the handshake link, bound to the top level.
// ----------------------------------------------------------------------------
module pphl_checker import pphl_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic               op_done_i,
  input logic [StatusW-1:0] status_code_i,
  input logic [ByteW-1:0]   rx_byte_i,
  input logic               engine_busy_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_req_yields_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("accepted request produced no result");

  a_status_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_code_i != ST_OK |-> op_done_i && !engine_busy_i)
    else $error("timeout status without completion");

  a_rx_needs_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && rx_byte_i != '0 |-> op_done_i && status_code_i == ST_OK)
    else $error("received byte outside a good completion");

endmodule

bind parallel_port_handshake_link pphl_checker u_pphl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_chan.valid),
  .in_ready_i    (in_chan.ready),
  .out_valid_i   (out_chan.valid),
  .out_ready_i   (out_chan.ready),
  .op_done_i     (out_chan.op_done),
  .status_code_i (out_chan.status_code),
  .rx_byte_i     (out_chan.rx_byte),
  .engine_busy_i (out_chan.engine_busy)
);

>>> dv/parallel_port_handshake_link_tb.sv
// ----------------------------------------------------------------------------
// parallel_port_handshake_link_tb
// Drives ticks and commands into the link and predicts every result with
// its own copy of the send/receive handshake state. Directed tests cover
// idle ticks, clear, send, receive with parity retry, commands while busy,
// every timeout status and extreme wait limits. Random traffic then runs
// under several limit settings, with idling on both channels and a long
// output stall.
// ----------------------------------------------------------------------------
module parallel_port_handshake_link_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pphl_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam int unsigned IDLE_PCT    = 19;

  typedef enum logic [3:0] {
    LINK_IDLE,
    SEND_ACK_HI,
    SEND_ACK_LO,
    RECV_EDGE1,
    RECV_EDGE2,
    RECV_EDGE3,
    RECV_EDGE4
  } link_phase_e;

  logic clk;
  logic rst_n;

  pphl_in_if  in_if ();
  pphl_out_if out_if ();
  pphl_cfg_if cfg_if ();

  parallel_port_handshake_link u_top (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  link_phase_e       link_phase;
  logic [LimitW-1:0] send_limit;
  logic [LimitW-1:0] recv_limit;
  logic [LimitW-1:0] wait_ticks;
  logic [ByteW-1:0]  rx_shift;
  logic              parity_bad;
  logic [ByteW-1:0]  drive_data;
  logic              drive_sel;
  logic [TallyW-1:0] tally;

  result_t     expected_results[$];
  int unsigned mismatch_count;
  int unsigned in_idle_pct;
  int unsigned out_idle_pct;
  int unsigned out_hold_req;
  int unsigned cycle_count;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic ack_goal(link_phase_e ph);
    return (ph == SEND_ACK_HI || ph == RECV_EDGE1 || ph == RECV_EDGE3);
  endfunction

  function automatic void reset_link_state();
    send_limit = SEND_LIMIT_RST;
    recv_limit = RECV_LIMIT_RST;
    link_phase = LINK_IDLE;
    wait_ticks = '0;
    rx_shift   = '0;
    parity_bad = 1'b0;
    drive_data = '0;
    drive_sel  = 1'b1;
    tally      = '0;
  endfunction

  function automatic result_t predict_link(request_t r);
    result_t           res;
    logic              nbusy;
    logic              is_send;
    logic [LimitW-1:0] lim;
    res = '0;
    nbusy = ~r.busy_line;
    if (r.cmd != CMD_TICK) begin
      if (link_phase == LINK_IDLE) begin
        case (r.cmd)
          CMD_CLEAR: begin
            drive_sel  = 1'b1;
            drive_data = '0;
            tally      = '0;
          end
          CMD_SEND: begin
            drive_data = r.tx_byte;
            drive_sel  = 1'b0;
            wait_ticks = '0;
            link_phase = SEND_ACK_HI;
          end
          default: begin
            wait_ticks = '0;
            link_phase = RECV_EDGE1;
          end
        endcase
      end
    end else if (link_phase != LINK_IDLE) begin
      is_send = (link_phase == SEND_ACK_HI || link_phase == SEND_ACK_LO);
      lim = is_send ? send_limit : recv_limit;
      if (r.ack_line == ack_goal(link_phase)) begin
        wait_ticks = '0;
        case (link_phase)
          SEND_ACK_HI: begin
            drive_sel  = 1'b1;
            link_phase = SEND_ACK_LO;
          end
          SEND_ACK_LO: begin
            res.op_done = 1'b1;
            link_phase  = LINK_IDLE;
          end
          RECV_EDGE1: begin
            rx_shift   = {5'b0, nbusy, r.paperout_line, r.select_line};
            drive_sel  = 1'b0;
            link_phase = RECV_EDGE2;
          end
          RECV_EDGE2: begin
            rx_shift[5:3] = {nbusy, r.paperout_line, r.select_line};
            drive_sel     = 1'b1;
            link_phase    = RECV_EDGE3;
          end
          RECV_EDGE3: begin
            rx_shift[7:6] = {r.paperout_line, r.select_line};
            if (nbusy != ^rx_shift) begin
              drive_data = PARITY_FAIL_BYTE;
              parity_bad = 1'b1;
              if (tally != '1) tally = tally + 1'b1;
            end else begin
              drive_data = '0;
              parity_bad = 1'b0;
            end
            drive_sel  = 1'b0;
            link_phase = RECV_EDGE4;
          end
          default: begin
            drive_sel = 1'b1;
            if (parity_bad) begin
              link_phase = RECV_EDGE1;
            end else begin
              res.op_done = 1'b1;
              res.rx_byte = rx_shift;
              link_phase  = LINK_IDLE;
            end
          end
        endcase
      end else if (wait_ticks >= lim) begin
        case (link_phase)
          SEND_ACK_HI:            res.status_code = ST_SEND_RISE;
          SEND_ACK_LO:            res.status_code = ST_SEND_FALL;
          RECV_EDGE1, RECV_EDGE2: res.status_code = ST_RECV_EDGE12;
          RECV_EDGE3:             res.status_code = ST_RECV_EDGE3;
          default:                res.status_code = ST_RECV_FINAL;
        endcase
        drive_sel   = 1'b1;
        res.op_done = 1'b1;
        link_phase  = LINK_IDLE;
        wait_ticks  = '0;
      end else begin
        wait_ticks = wait_ticks + 1'b1;
      end
    end
    res.data_drive    = drive_data;
    res.select_ctrl   = drive_sel;
    res.engine_busy   = (link_phase != LINK_IDLE);
    res.ack_pending   = r.ack_line;
    res.parity_errors = tally;
    return res;
  endfunction

  // A tick that meets the awaited ack level with the given odds; on the third
  // receive edge the busy line carries correct parity with the given odds.
  function automatic request_t make_tick(int unsigned hit_pct, int unsigned good_pct);
    request_t r;
    logic     par;
    r.cmd           = CMD_TICK;
    r.tx_byte       = ByteW'($urandom);
    r.select_line   = 1'($urandom);
    r.paperout_line = 1'($urandom);
    r.busy_line     = 1'($urandom);
    if ($urandom_range(99) < hit_pct) r.ack_line = ack_goal(link_phase);
    else r.ack_line = ~ack_goal(link_phase);
    if (link_phase == RECV_EDGE3) begin
      par = ^{rx_shift[5:0], r.paperout_line, r.select_line};
      r.busy_line = ($urandom_range(99) < good_pct) ? ~par : par;
    end
    return r;
  endfunction

  task automatic drive_req(request_t r);
    in_if.valid         <= 1'b1;
    in_if.cmd           <= r.cmd;
    in_if.tx_byte       <= r.tx_byte;
    in_if.ack_line      <= r.ack_line;
    in_if.select_line   <= r.select_line;
    in_if.paperout_line <= r.paperout_line;
    in_if.busy_line     <= r.busy_line;
    do @(posedge clk); while (!in_if.ready);
    expected_results.push_back(predict_link(r));
    while ($urandom_range(99) < in_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic tick(logic ack, logic sel, logic po, logic busy);
    drive_req('{CMD_TICK, ByteW'($urandom), ack, sel, po, busy});
  endtask

  task automatic issue(logic [CmdW-1:0] cmd, logic [ByteW-1:0] tx);
    drive_req('{cmd, tx, 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom)});
  endtask

  task automatic settle_link();
    while (link_phase != LINK_IDLE) drive_req(make_tick(100, 100));
    in_if.valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic write_limit(logic [CfgIdxW-1:0] idx, logic [LimitW-1:0] value);
    settle_link();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx == REG_SEND_LIMIT) send_limit = value;
    else if (idx == REG_RECV_LIMIT) recv_limit = value;
  endtask

  task automatic run_traffic(int unsigned n_items);
    int unsigned done_items;
    int unsigned pick;
    request_t    r;
    done_items = 0;
    while (done_items < n_items) begin
      pick = $urandom_range(99);
      r = make_tick(70, 75);
      if (link_phase == LINK_IDLE) begin
        if (pick < 42) r.cmd = CMD_SEND;
        else if (pick < 82) r.cmd = CMD_RECV;
        else if (pick < 88) r.cmd = CMD_CLEAR;
        if (r.cmd != CMD_TICK) done_items++;
      end else if (pick < 92) begin
        done_items++;
      end else begin
        r.cmd = CmdW'($urandom_range(CMD_RECV, CMD_CLEAR));
      end
      drive_req(r);
    end
  endtask

  task automatic test_idle_and_clear();
    tick(1'b0, 1'b0, 1'b0, 1'b0);
    tick(1'b1, 1'b1, 1'b1, 1'b1);
    issue(CMD_CLEAR, 8'hff);
  endtask

  task automatic test_send_transfer();
    issue(CMD_SEND, 8'hff);
    tick(1'b0, 1'b1, 1'b1, 1'b1);
    tick(1'b1, 1'b0, 1'b0, 1'b0);
    tick(1'b1, 1'b0, 1'b1, 1'b0);
    tick(1'b0, 1'b1, 1'b0, 1'b1);
    issue(CMD_SEND, 8'h00);
    tick(1'b1, 1'b0, 1'b0, 1'b0);
    tick(1'b0, 1'b0, 1'b0, 1'b0);
  endtask

  task automatic test_receive_and_retry();
    issue(CMD_RECV, 8'h00);
    tick(1'b0, 1'b1, 1'b1, 1'b1);
    tick(1'b1, 1'b1, 1'b0, 1'b0);
    issue(CMD_SEND, 8'h5a);
    tick(1'b0, 1'b0, 1'b1, 1'b1);
    issue(CMD_CLEAR, 8'h00);
    drive_req(make_tick(100, 0));
    issue(CMD_RECV, 8'h00);
    tick(1'b0, 1'b0, 1'b0, 1'b0);
    settle_link();
    issue(CMD_RECV, 8'h00);
    tick(1'b1, 1'b1, 1'b1, 1'b0);
    tick(1'b0, 1'b1, 1'b1, 1'b0);
    tick(1'b1, 1'b1, 1'b1, 1'b1);
    tick(1'b0, 1'b1, 1'b1, 1'b0);
    issue(CMD_CLEAR, 8'h00);
  endtask

  task automatic test_wait_timeouts();
    write_limit(REG_SEND_LIMIT, '0);
    write_limit(REG_RECV_LIMIT, '0);
    issue(CMD_SEND, 8'h81);
    tick(1'b0, 1'b0, 1'b0, 1'b0);
    issue(CMD_SEND, 8'h7e);
    tick(1'b1, 1'b0, 1'b0, 1'b0);
    tick(1'b1, 1'b0, 1'b0, 1'b0);
    issue(CMD_RECV, 8'h00);
    tick(1'b0, 1'b0, 1'b0, 1'b0);
    issue(CMD_RECV, 8'h00);
    tick(1'b1, 1'b1, 1'b0, 1'b1);
    tick(1'b1, 1'b0, 1'b0, 1'b0);
    issue(CMD_RECV, 8'h00);
    tick(1'b1, 1'b0, 1'b1, 1'b0);
    tick(1'b0, 1'b1, 1'b0, 1'b1);
    tick(1'b0, 1'b0, 1'b0, 1'b0);
    issue(CMD_RECV, 8'h00);
    tick(1'b1, 1'b0, 1'b0, 1'b1);
    tick(1'b0, 1'b0, 1'b0, 1'b1);
    tick(1'b1, 1'b0, 1'b0, 1'b1);
    tick(1'b1, 1'b0, 1'b0, 1'b0);
  endtask

  task automatic test_long_limits();
    write_limit(REG_SEND_LIMIT, '1);
    write_limit(REG_RECV_LIMIT, '1);
    issue(CMD_SEND, ByteW'($urandom));
    repeat (6) drive_req(make_tick(0, 100));
    settle_link();
    issue(CMD_RECV, 8'h00);
    repeat (20) drive_req(make_tick(40, 50));
    settle_link();
  endtask

  task automatic test_output_backpressure();
    settle_link();
    in_idle_pct  = 0;
    out_hold_req = 150;
    run_traffic(40);
    in_idle_pct  = IDLE_PCT;
  endtask

  task automatic test_random_traffic();
    write_limit(REG_SEND_LIMIT, 17'd2);
    write_limit(REG_RECV_LIMIT, 17'd1);
    run_traffic(100);
    write_limit(REG_SEND_LIMIT, '0);
    write_limit(REG_RECV_LIMIT, '0);
    run_traffic(100);
    write_limit(REG_SEND_LIMIT, 17'd20);
    write_limit(REG_RECV_LIMIT, 17'd12);
    in_idle_pct  = 0;
    out_idle_pct = 0;
    run_traffic(100);
    in_idle_pct  = IDLE_PCT;
    out_idle_pct = IDLE_PCT;
    write_limit(REG_SEND_LIMIT, 17'd6);
    write_limit(REG_RECV_LIMIT, 17'd3);
    run_traffic(100);
  endtask

  initial begin
    result_t got;
    result_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        got.data_drive    = out_if.data_drive;
        got.select_ctrl   = out_if.select_ctrl;
        got.op_done       = out_if.op_done;
        got.status_code   = out_if.status_code;
        got.rx_byte       = out_if.rx_byte;
        got.engine_busy   = out_if.engine_busy;
        got.ack_pending   = out_if.ack_pending;
        got.parity_errors = out_if.parity_errors;
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected result data=%h", got.data_drive);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("mismatch exp: data=%h sel=%b done=%b st=%0d rx=%h busy=%b ack=%b tally=%0d",
                       want.data_drive, want.select_ctrl, want.op_done, want.status_code,
                       want.rx_byte, want.engine_busy, want.ack_pending, want.parity_errors);
              $display("         got: data=%h sel=%b done=%b st=%0d rx=%h busy=%b ack=%b tally=%0d",
                       got.data_drive, got.select_ctrl, got.op_done, got.status_code,
                       got.rx_byte, got.engine_busy, got.ack_pending, got.parity_errors);
            end
          end
        end
      end
    end
  end

  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_hold_req != 0) begin
        hold_left    = out_hold_req;
        out_hold_req = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    mismatch_count = 0;
    in_idle_pct    = IDLE_PCT;
    out_idle_pct   = IDLE_PCT;
    out_hold_req   = 0;
    reset_link_state();
    in_if.valid         <= 1'b0;
    in_if.cmd           <= CMD_TICK;
    in_if.tx_byte       <= '0;
    in_if.ack_line      <= 1'b0;
    in_if.select_line   <= 1'b0;
    in_if.paperout_line <= 1'b0;
    in_if.busy_line     <= 1'b0;
    cfg_if.valid        <= 1'b0;
    cfg_if.index        <= REG_SEND_LIMIT;
    cfg_if.data         <= '0;
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_and_clear();
    test_send_transfer();
    test_receive_and_retry();
    test_wait_timeouts();
    test_long_limits();
    test_output_backpressure();
    test_random_traffic();

    settle_link();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/pphl_pkg.sv
hdl/pphl_if.sv
hdl/pphl_engine.sv
hdl/parallel_port_handshake_link.sv
hdl/pphl_checker.sv
dv/parallel_port_handshake_link_tb.sv
